@@ rtl/pbvd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Planar bitmap video decoder package
// Shared widths, defaults and operation/mode codes for the decoder.
// ---------------------------------------------------------------------------
package pbvd_pkg;

  // Default number of 8-colour pixel pairs on one line.
  localparam int PIXELS_PER_LINE_DEF = 256;

  localparam int BYTE_W      = 8;
  localparam int PIX_W       = 3;
  localparam int NUM_PIXELS  = 8;
  localparam int NUM_PAIRS   = 4;
  localparam int FRAME_CNT_W = 6;

  // Frame counter bit that selects the held colour for flashing pixels.
  localparam int FLASH_FRAME_BIT = FRAME_CNT_W - 1;

  // Operation codes of an input word.
  localparam logic OP_DECODE    = 1'b0;
  localparam logic OP_FRAME_END = 1'b1;

  // Display mode codes.
  localparam logic MODE_EIGHT = 1'b0;
  localparam logic MODE_FOUR  = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

endpackage : pbvd_pkg

@@ rtl/planar_bitmap_video_decoder_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Planar bitmap video decoder unit
// Turns one 16-bit screen word into eight 3-bit colour indices in 4-colour
// or 8-colour (flash, doubled pixels) mode, and tracks frame and line state.
// ---------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_ready    | in_operation, in_even_byte, in_odd_byte
//  out     | out_valid / out_ready  | out_pixel_0 .. out_pixel_7
//  cfg     | cfg_valid / cfg_ready  | cfg_display_mode
//
// One word is accepted per cycle while the input register can move on. A
// decode word is held in the input register after it is accepted, and the
// decode logic writes its result into the result register once that has room. A
// frame-end word leaves the input register in the next cycle without
// producing a result.
// A stalled output holds its word and backs up into the input register; the
// input stays ready as long as the input register can move on in that cycle.
// Reset (rst_n low, synchronous) empties both registers, clears the frame
// counter, flash state and line position, and selects 8-colour mode.
// ---------------------------------------------------------------------------
module planar_bitmap_video_decoder_unit
  import pbvd_pkg::*;
#(
  parameter int PIXELS_PER_LINE = PIXELS_PER_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [BYTE_W-1:0] in_even_byte,
  input  logic [BYTE_W-1:0] in_odd_byte,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_pixel_0,
  output logic [PIX_W-1:0]  out_pixel_1,
  output logic [PIX_W-1:0]  out_pixel_2,
  output logic [PIX_W-1:0]  out_pixel_3,
  output logic [PIX_W-1:0]  out_pixel_4,
  output logic [PIX_W-1:0]  out_pixel_5,
  output logic [PIX_W-1:0]  out_pixel_6,
  output logic [PIX_W-1:0]  out_pixel_7,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_display_mode
);

  // The line position always stays below PIXELS_PER_LINE.
  localparam int LPW = $clog2(PIXELS_PER_LINE);
  localparam logic [LPW:0] LINE_END = (LPW+1)'(PIXELS_PER_LINE);

  // Configuration register; the port never stalls.
  logic display_mode_r;

  // Input register.
  logic              s1_valid_r;
  logic              s1_op_r;
  logic [BYTE_W-1:0] s1_even_r;
  logic [BYTE_W-1:0] s1_odd_r;

  // Decoder state.
  logic [FRAME_CNT_W-1:0] frame_cnt_r, frame_cnt_nxt;
  logic                   flash_act_r, flash_act_nxt;
  pix_t                   flash_col_r, flash_col_nxt;
  logic [LPW-1:0]         line_pos_r, line_pos_nxt;

  // Result register.
  logic out_valid_r;
  pix_t pix_r   [NUM_PIXELS];
  pix_t pix_nxt [NUM_PIXELS];

  logic s2_ready;
  logic s1_fire;
  logic emit;

  // The result register can take a new word when it is empty or being drained.
  assign s2_ready = !out_valid_r || out_ready;
  // A frame-end word needs no room in the result register.
  assign s1_fire  = s1_valid_r && ((s1_op_r == OP_FRAME_END) || s2_ready);
  assign emit     = s1_fire && (s1_op_r == OP_DECODE);
  assign in_ready = !s1_valid_r || s1_fire;

  assign cfg_ready = 1'b1;

  // Decode logic. In 8-colour mode the four pixel pairs are walked left to
  // right, since each flash bit changes the hold state seen by the next pair.
  always_comb begin
    logic [1:0]   pe;
    logic [1:0]   po;
    pix_t         colour;
    pix_t         shown;
    logic [LPW:0] lp_sum;
    logic         g;
    logic         r;

    pe            = '0;
    po            = '0;
    colour        = '0;
    shown         = '0;
    lp_sum        = '0;
    g             = 1'b0;
    r             = 1'b0;
    frame_cnt_nxt = frame_cnt_r;
    flash_act_nxt = flash_act_r;
    flash_col_nxt = flash_col_r;
    line_pos_nxt  = line_pos_r;
    for (int k = 0; k < NUM_PIXELS; k++) begin
      pix_nxt[k] = '0;
    end

    if (s1_op_r == OP_FRAME_END) begin
      // End of frame: advance the counter, drop all flash state and restart the line.
      frame_cnt_nxt = frame_cnt_r + 1'b1;
      flash_act_nxt = 1'b0;
      flash_col_nxt = '0;
      line_pos_nxt  = '0;
    end else if (display_mode_r == MODE_FOUR) begin
      // Even byte bit is green, odd byte bit is red; both set gives white.
      for (int k = 0; k < NUM_PIXELS; k++) begin
        g          = s1_even_r[NUM_PIXELS-1-k];
        r          = s1_odd_r[NUM_PIXELS-1-k];
        pix_nxt[k] = {g, r, g & r};
      end
    end else begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
        pe     = s1_even_r[(2*(NUM_PAIRS-1-k)) +: 2];
        po     = s1_odd_r[(2*(NUM_PAIRS-1-k)) +: 2];
        colour = {pe[1], po};
        // While hold mode is on, the held colour shows in the flash phase.
        if (frame_cnt_r[FLASH_FRAME_BIT] && flash_act_nxt) begin
          shown = flash_col_nxt;
        end else begin
          shown = colour;
        end
        pix_nxt[2*k]   = shown;
        pix_nxt[2*k+1] = shown;

        // The flash bit toggles hold mode after its pixel is shown; turning
        // it on captures the colour that was just shown.
        if (pe[0]) begin
          if (!flash_act_nxt) begin
            flash_col_nxt = shown;
            flash_act_nxt = 1'b1;
          end else begin
            flash_act_nxt = 1'b0;
          end
        end

        // At the end of a line the position wraps and flash state clears.
        lp_sum = {1'b0, line_pos_nxt} + 1'b1;
        if (lp_sum == LINE_END) begin
          line_pos_nxt  = '0;
          flash_col_nxt = '0;
          flash_act_nxt = 1'b0;
        end else begin
          line_pos_nxt  = lp_sum[LPW-1:0];
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_mode_r <= MODE_EIGHT;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      frame_cnt_r    <= '0;
      flash_act_r    <= 1'b0;
      flash_col_r    <= '0;
      line_pos_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        display_mode_r <= cfg_display_mode;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        frame_cnt_r <= frame_cnt_nxt;
        flash_act_r <= flash_act_nxt;
        flash_col_r <= flash_col_nxt;
        line_pos_r  <= line_pos_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= in_operation;
      s1_even_r <= in_even_byte;
      s1_odd_r  <= in_odd_byte;
    end
    if (emit) begin
      for (int k = 0; k < NUM_PIXELS; k++) begin
        pix_r[k] <= pix_nxt[k];
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_0 = pix_r[0];
  assign out_pixel_1 = pix_r[1];
  assign out_pixel_2 = pix_r[2];
  assign out_pixel_3 = pix_r[3];
  assign out_pixel_4 = pix_r[4];
  assign out_pixel_5 = pix_r[5];
  assign out_pixel_6 = pix_r[6];
  assign out_pixel_7 = pix_r[7];

endmodule : planar_bitmap_video_decoder_unit

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Planar bitmap video decoder unit testbench
// Drives screen words and frame-end words through the decoder in both
// display modes. It predicts every pixel row in a scoreboard and compares
// each returned row pixel by pixel, under random idling and a long output
// stall.
// ---------------------------------------------------------------------------
module tb;
  import pbvd_pkg::*;

  // One decoded result: index k holds pixel_k, pixel_0 leftmost.
  typedef logic [NUM_PIXELS-1:0][PIX_W-1:0] pixel_row_t;

  // Cycles in which nothing is accepted anywhere before the run is
  // declared hung. The longest correct quiet spell is the forced output
  // hold plus one long gap, far below this.
  localparam int IDLE_LIMIT    = 2000;
  // Length of the forced output hold-off.
  localparam int HOLD_CYCLES   = 300;
  // Cycles to let pass after the last expected row before touching the
  // mode register; covers a frame-end word still in the input register.
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_WORDS   = 200;

  // Chance of a frame-end word per phase, out of 256. Phase 2 has none so
  // that lines wrap; phase 3 pushes the frame counter around quickly.
  int frame_end_rate [NUM_PHASES] = '{32, 32, 0, 85, 16, 4, 0, 32};

  // -------------------------------------------------------------------------
  // Scoreboard: mirrors the decoder state and keeps the rows still owed.
  // -------------------------------------------------------------------------
  class row_tracker;
    logic       mode;
    logic [5:0] frame_count;
    logic       flash_active;
    pix_t       flash_colour;
    int         line_pos;
    pixel_row_t pending_rows[$];
    int         errors;
    int         rows_checked;
    int         frame_ends;
    int         line_wraps;
    int         held_shown;

    function new();
      mode         = MODE_EIGHT;
      frame_count  = '0;
      flash_active = 1'b0;
      flash_colour = '0;
      line_pos     = 0;
      errors       = 0;
      rows_checked = 0;
      frame_ends   = 0;
      line_wraps   = 0;
      held_shown   = 0;
    endfunction

    function void set_mode(logic m);
      mode = m;
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction

    // Works out the row that an accepted word will produce, if any.
    function void predict_word(logic op, logic [7:0] ev, logic [7:0] od);
      pixel_row_t row;
      logic       g;
      logic       r;
      logic [1:0] pe;
      logic [1:0] po;
      pix_t       colour;
      pix_t       shown;
      if (op == OP_FRAME_END) begin
        frame_count  = frame_count + 1'b1;
        flash_active = 1'b0;
        flash_colour = '0;
        line_pos     = 0;
        frame_ends++;
        return;
      end
      if (mode == MODE_FOUR) begin
        for (int k = 0; k < NUM_PIXELS; k++) begin
          g      = ev[7-k];
          r      = od[7-k];
          row[k] = {g, r, g & r};
        end
      end else begin
        for (int k = 0; k < NUM_PAIRS; k++) begin
          pe     = ev[7-2*k -: 2];
          po     = od[7-2*k -: 2];
          colour = {pe[1], po};
          shown  = colour;
          if (frame_count[FLASH_FRAME_BIT] && flash_active) begin
            shown = flash_colour;
            held_shown++;
          end
          row[2*k]   = shown;
          row[2*k+1] = shown;
          // The flash bit takes effect after its own pixel is shown.
          if (pe[0]) begin
            if (!flash_active) begin
              flash_colour = shown;
              flash_active = 1'b1;
            end else begin
              flash_active = 1'b0;
            end
          end
          line_pos++;
          if (line_pos >= PIXELS_PER_LINE_DEF) begin
            line_pos     = 0;
            flash_colour = '0;
            flash_active = 1'b0;
            line_wraps++;
          end
        end
      end
      pending_rows.push_back(row);
    endfunction

    // Compares a returned row with the oldest one owed.
    function void check_row(pixel_row_t got);
      pixel_row_t want;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_rows.pop_front();
      rows_checked++;
      for (int k = 0; k < NUM_PIXELS; k++) begin
        if (want[k] !== got[k]) begin
          $display("%0t: pixel_%0d mismatch, expected %0d, actual %0d",
                   $time, k, want[k], got[k]);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_operation;
  logic [BYTE_W-1:0] in_even_byte;
  logic [BYTE_W-1:0] in_odd_byte;
  logic              out_valid;
  logic              out_ready;
  logic [PIX_W-1:0]  out_pixel_0;
  logic [PIX_W-1:0]  out_pixel_1;
  logic [PIX_W-1:0]  out_pixel_2;
  logic [PIX_W-1:0]  out_pixel_3;
  logic [PIX_W-1:0]  out_pixel_4;
  logic [PIX_W-1:0]  out_pixel_5;
  logic [PIX_W-1:0]  out_pixel_6;
  logic [PIX_W-1:0]  out_pixel_7;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_display_mode;

  row_tracker sb;

  // Set by the stimulus to ask the receiver for one long hold-off; the
  // receiver clears it once the hold is over.
  bit hold_req;
  // While set, neither side inserts gaps.
  bit no_idle;
  int idle_cycles;

  planar_bitmap_video_decoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_even_byte     (in_even_byte),
    .in_odd_byte      (in_odd_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_0      (out_pixel_0),
    .out_pixel_1      (out_pixel_1),
    .out_pixel_2      (out_pixel_2),
    .out_pixel_3      (out_pixel_3),
    .out_pixel_4      (out_pixel_4),
    .out_pixel_5      (out_pixel_5),
    .out_pixel_6      (out_pixel_6),
    .out_pixel_7      (out_pixel_7),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_display_mode (cfg_display_mode)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap lengths: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // -------------------------------------------------------------------------
  // Monitors. Everything is sampled at the rising edge; the testbench only
  // changes inputs at the falling edge, so the sampled values are settled.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.predict_word(in_operation, in_even_byte, in_odd_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_row({out_pixel_7, out_pixel_6, out_pixel_5, out_pixel_4,
                    out_pixel_3, out_pixel_2, out_pixel_1, out_pixel_0});
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready)
      sb.set_mode(cfg_display_mode);
  end

  // The watchdog restarts its count on any accepted word, on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
          $display("planar_bitmap_video_decoder_unit test failed");
          $finish;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver. It keeps out_ready high for short bursts with random gaps in
  // between, and on request holds it low for a long, counted stretch so the
  // decoder fills up and has to stall its input.
  // -------------------------------------------------------------------------
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          @(negedge clk);
          out_ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  // Offers one word after a random gap and returns at the falling edge that
  // follows its acceptance, with in_valid still high so that a word sent
  // straight after keeps the channel busy without a bubble.
  task automatic send_word(logic op, logic [7:0] ev, logic [7:0] od);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_even_byte <= ev;
    in_odd_byte  <= od;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stops offering words and waits until every owed row has come back,
  // then lets a frame-end word that causes no row clear the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The mode register is only written with the decoder empty.
  task automatic write_mode(logic m);
    drain();
    cfg_valid        <= 1'b1;
    cfg_display_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    logic m;
    logic op;
    int   rate;
    sb               = new();
    hold_req         = 1'b0;
    no_idle          = 1'b0;
    idle_cycles      = 0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_DECODE;
    in_even_byte     = '0;
    in_odd_byte      = '0;
    out_ready        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_display_mode = MODE_EIGHT;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words in 8-colour mode: all-zero and all-one bytes, each
    // byte alone, alternating bit patterns, a flash bit that captures the
    // shown colour, a word whose flash bits toggle hold mode on and off,
    // and frame ends in between.
    write_mode(MODE_EIGHT);
    send_word(OP_DECODE, 8'h00, 8'h00);
    send_word(OP_DECODE, 8'hFF, 8'hFF);
    send_word(OP_DECODE, 8'hFF, 8'h00);
    send_word(OP_DECODE, 8'h00, 8'hFF);
    send_word(OP_DECODE, 8'hAA, 8'h55);
    send_word(OP_DECODE, 8'h55, 8'hAA);
    send_word(OP_DECODE, 8'h40, 8'hC0);
    send_word(OP_DECODE, 8'h41, 8'h03);
    send_word(OP_FRAME_END, 8'hFF, 8'hFF);
    send_word(OP_DECODE, 8'h80, 8'hFF);
    send_word(OP_FRAME_END, 8'h00, 8'h00);

    // An 8-colour word that turns hold mode on, then 4-colour words, where green
    // and red together give white; 4-colour words leave the flash state alone.
    send_word(OP_DECODE, 8'h40, 8'h00);
    write_mode(MODE_FOUR);
    send_word(OP_DECODE, 8'h00, 8'h00);
    send_word(OP_DECODE, 8'hFF, 8'hFF);
    send_word(OP_DECODE, 8'hFF, 8'h00);
    send_word(OP_DECODE, 8'h00, 8'hFF);
    send_word(OP_DECODE, 8'hAA, 8'h55);
    send_word(OP_DECODE, 8'h81, 8'h18);
    send_word(OP_FRAME_END, 8'h5A, 8'hA5);
    write_mode(MODE_EIGHT);
    send_word(OP_DECODE, 8'h55, 8'h55);
    send_word(OP_DECODE, 8'h01, 8'h01);

    // Random phases. Each starts with a mode write, which first waits for
    // the decoder to drain completely. Phase 2 also asks the receiver for
    // its long hold-off while words keep coming.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1, 4:    m = MODE_FOUR;
        6:       m = logic'($urandom_range(0, 1));
        default: m = MODE_EIGHT;
      endcase
      write_mode(m);
      no_idle = (p == 4 || p == 7);
      rate    = (p == 6) ? $urandom_range(0, 100) : frame_end_rate[p];
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        op = ($urandom_range(0, 255) < rate) ? OP_FRAME_END : OP_DECODE;
        send_word(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end

    drain();
    $display("Checked %0d rows in both display modes, with %0d frame ends and %0d line wraps.",
             sb.rows_checked, sb.frame_ends, sb.line_wraps);
    $display("Held colour was shown for %0d pixel pairs; %0d mismatches were found.",
             sb.held_shown, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("planar_bitmap_video_decoder_unit test passed");
    end else begin
      $display("planar_bitmap_video_decoder_unit test failed");
    end
    $finish;
  end

endmodule
